// File: rtl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// Laser safety interlock package
// Shared types, codes, field layout and reset values for the interlock.
// ----------------------------------------------------------------------------
package lsi_pkg;

	// Command codes carried in the input tuser
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_FEED      = 3'd1,
		CMD_CHECK     = 3'd2,
		CMD_SET_DET   = 3'd3,
		CMD_TILT      = 3'd4,
		CMD_SET_VOLT  = 3'd5,
		CMD_SAFE      = 3'd6,
		CMD_RESET     = 3'd7
	} cmd_t;

	// Operating mode
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_WARNING = 2'd1,
		MODE_SAFE    = 2'd2
	} mode_t;

	// Reported status
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_NOT_ARMED = 4'd1,
		ST_NO_DET    = 4'd2,
		ST_TILT      = 4'd3,
		ST_TIME      = 4'd4,
		ST_KILL      = 4'd5,
		ST_WATCHDOG  = 4'd6,
		ST_BROWNOUT  = 4'd7,
		ST_SAFE      = 4'd8,
		ST_MULTIPLE  = 4'd9
	} status_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_WD_TIMEOUT = 3'd0,
		REG_WD_WARNING = 3'd1,
		REG_TILT_LIMIT = 3'd2,
		REG_VOLT_MIN   = 3'd3,
		REG_VOLT_WARN  = 3'd4,
		REG_ON_LIMIT   = 3'd5
	} reg_idx_t;

	// Check mask bit positions
	localparam int unsigned CHK_ARMED    = 0;
	localparam int unsigned CHK_DET      = 1;
	localparam int unsigned CHK_TILT     = 2;
	localparam int unsigned CHK_TIME     = 3;
	localparam int unsigned CHK_KILL     = 4;
	localparam int unsigned CHK_WATCHDOG = 5;
	localparam int unsigned CHK_BROWNOUT = 6;

	localparam logic [6:0] ALL_CHECKS = 7'h7F;

	// Widths
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned IN_USED_W  = 53;
	localparam int unsigned OUT_DATA_W = 40;

	// Reset values
	localparam logic [15:0]        WD_TIMEOUT_RST = 16'd30000;
	localparam logic [15:0]        WD_WARNING_RST = 16'd25000;
	localparam logic signed [10:0] TILT_LIMIT_RST = 11'sd0;
	localparam logic [15:0]        VOLT_MIN_RST   = 16'd4500;
	localparam logic [15:0]        VOLT_WARN_RST  = 16'd4750;
	localparam logic [15:0]        ON_LIMIT_RST   = 16'd10000;
	localparam logic [15:0]        VOLTAGE_RST    = 16'd5000;

	// Single status from a failure mask: the code of the one failed check, or ST_MULTIPLE
	function automatic status_t fail_status(input logic [6:0] failed);
		status_t st;
		st = ST_MULTIPLE;
		if (failed == 7'd0) begin
			st = ST_OK;
		end else if ($countones(failed) == 1) begin
			case (1'b1)
				failed[CHK_ARMED]:    st = ST_NOT_ARMED;
				failed[CHK_DET]:      st = ST_NO_DET;
				failed[CHK_TILT]:     st = ST_TILT;
				failed[CHK_TIME]:     st = ST_TIME;
				failed[CHK_KILL]:     st = ST_KILL;
				failed[CHK_WATCHDOG]: st = ST_WATCHDOG;
				default:              st = ST_BROWNOUT;
			endcase
		end
		return st;
	endfunction

endpackage

// File: rtl/laser_safety_interlock.sv
// ----------------------------------------------------------------------------
// Laser safety interlock
// Watchdog, brownout, tilt and check logic guarding a laser, one command per
// input item and one result item per command.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  one command item (tuser) + operands
// m_*       out        m_tvalid / m_tready  one result item per command
// cfg_*     in         cfg_we               register write, no read-back
//
// Every item passes an input register and a result register, so a result
// is offered on m_* once its item has moved into the result register, and
// one item is taken in every cycle while the output side keeps up; the rate
// is set by the single state update done between those two registers.
// Reset (arst_n low) clears the valid flags, puts the mode in normal, clears
// the watchdog, stores 5000 mV and loads the configuration defaults.
// A stall on m_tready holds the result register; the input register then
// holds one more item before s_tready falls.
// ----------------------------------------------------------------------------
module laser_safety_interlock (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata, from bit 0: check_mask[7], armed_flag, kill_engaged,
	// laser_on_ms[16], detection_flag, tilt_value[11], supply_mv[16], zero pad
	input  logic [lsi_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: command[3]
	input  logic [2:0]                         s_tuser,
	// Result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata, from bit 0: status[4], failed_mask[7], watchdog_left_ms[16],
	// mode_now[2], warning_event, laser_kill, kill_release, voltage_low_warn,
	// brownout_now, detection_now, zero pad
	output logic [lsi_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Configuration writes
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);

	import lsi_pkg::*;

	// Configuration registers
	logic [15:0]        wd_timeout_q;
	logic [15:0]        wd_warning_q;
	logic signed [10:0] tilt_limit_q;
	logic [15:0]        volt_min_q;
	logic [15:0]        volt_warn_q;
	logic [15:0]        on_limit_q;

	// Interlock state
	mode_t              mode_q, mode_d;
	logic [15:0]        elapsed_q, elapsed_d;
	logic               fired_q, fired_d;
	logic               det_q, det_d;
	logic signed [10:0] tilt_q, tilt_d;
	logic [15:0]        volt_q, volt_d;

	// Input register
	logic                 valid_s1;
	logic [2:0]           cmd_s1;
	logic [IN_USED_W-1:0] data_s1;

	// Result register
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic adv_s1;

	// Operand fields of the item in the input register
	logic [6:0]         chk_mask;
	logic               armed;
	logic               killed;
	logic [15:0]        on_ms;
	logic               det_in;
	logic signed [10:0] tilt_in;
	logic [15:0]        supply_in;

	assign chk_mask  = data_s1[6:0];
	assign armed     = data_s1[7];
	assign killed    = data_s1[8];
	assign on_ms     = data_s1[24:9];
	assign det_in    = data_s1[25];
	assign tilt_in   = data_s1[36:26];
	assign supply_in = data_s1[52:37];

	// The input register moves on whenever the result register is free or
	// its item is being taken this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_timeout_q <= WD_TIMEOUT_RST;
			wd_warning_q <= WD_WARNING_RST;
			tilt_limit_q <= TILT_LIMIT_RST;
			volt_min_q   <= VOLT_MIN_RST;
			volt_warn_q  <= VOLT_WARN_RST;
			on_limit_q   <= ON_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WD_TIMEOUT: wd_timeout_q <= cfg_data;
				REG_WD_WARNING: wd_warning_q <= cfg_data;
				REG_TILT_LIMIT: tilt_limit_q <= cfg_data[10:0];
				REG_VOLT_MIN:   volt_min_q   <= cfg_data;
				REG_VOLT_WARN:  volt_warn_q  <= cfg_data;
				REG_ON_LIMIT:   on_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Command decode and next state
	// ------------------------------------------------------------------
	logic        brownout_q;
	logic        expired_q;
	logic [15:0] elapsed_inc;
	logic        tick_expire;
	logic [6:0]  failed_d;
	status_t     status_d;
	logic        warn_ev_d;
	logic        kill_d;
	logic        release_d;
	logic [15:0] left_d;
	logic        volt_low_d;
	logic        brown_d;

	// Brownout and expiry as seen before this item
	assign brownout_q  = (volt_q != 16'd0) && (volt_q < volt_min_q);
	assign expired_q   = elapsed_q >= wd_timeout_q;
	// Saturating watchdog count for a tick
	assign elapsed_inc = expired_q ? wd_timeout_q : (elapsed_q + 16'd1);
	assign tick_expire = elapsed_inc >= wd_timeout_q;

	always_comb begin
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		fired_d   = fired_q;
		det_d     = det_q;
		tilt_d    = tilt_q;
		volt_d    = volt_q;
		failed_d  = 7'd0;
		status_d  = ST_OK;
		warn_ev_d = 1'b0;
		kill_d    = 1'b0;
		release_d = 1'b0;
		unique case (cmd_t'(cmd_s1))
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (tick_expire) begin
					mode_d = MODE_SAFE;
				end else if (elapsed_inc >= wd_warning_q && !fired_q) begin
					// The warning fires once until the next feed or reset.
					fired_d   = 1'b1;
					warn_ev_d = 1'b1;
					if (mode_q == MODE_NORMAL) begin
						mode_d = MODE_WARNING;
					end
				end
				if (brownout_q) begin
					mode_d = MODE_SAFE;
				end
				kill_d = (mode_q != MODE_SAFE) && (tick_expire || brownout_q);
			end
			CMD_FEED: begin
				elapsed_d = 16'd0;
				fired_d   = 1'b0;
				if (mode_q == MODE_WARNING) begin
					mode_d = MODE_NORMAL;
				end
			end
			CMD_CHECK: begin
				if (mode_q == MODE_SAFE) begin
					status_d = ST_SAFE;
					failed_d = ALL_CHECKS;
				end else begin
					failed_d[CHK_ARMED]    = chk_mask[CHK_ARMED] && !armed;
					failed_d[CHK_DET]      = chk_mask[CHK_DET] && !det_q;
					failed_d[CHK_TILT]     = chk_mask[CHK_TILT] && (tilt_q > tilt_limit_q);
					failed_d[CHK_TIME]     = chk_mask[CHK_TIME] && (on_ms >= on_limit_q);
					failed_d[CHK_KILL]     = chk_mask[CHK_KILL] && killed;
					failed_d[CHK_WATCHDOG] = chk_mask[CHK_WATCHDOG] && expired_q;
					failed_d[CHK_BROWNOUT] = chk_mask[CHK_BROWNOUT] && brownout_q;
					status_d = fail_status(failed_d);
				end
			end
			CMD_SET_DET: begin
				det_d = det_in;
			end
			CMD_TILT: begin
				tilt_d = tilt_in;
				if (tilt_in > tilt_limit_q) begin
					status_d           = ST_TILT;
					failed_d[CHK_TILT] = 1'b1;
				end
			end
			CMD_SET_VOLT: begin
				volt_d = supply_in;
			end
			CMD_SAFE: begin
				mode_d = MODE_SAFE;
				kill_d = (mode_q != MODE_SAFE);
			end
			CMD_RESET: begin
				// Only a reset out of safe mode has any effect.
				if (mode_q == MODE_SAFE) begin
					elapsed_d = 16'd0;
					fired_d   = 1'b0;
					release_d = 1'b1;
					mode_d    = MODE_NORMAL;
				end
			end
		endcase
	end

	// Result fields taken from the state after this item
	assign left_d     = (elapsed_d >= wd_timeout_q) ? 16'd0 : (wd_timeout_q - elapsed_d);
	assign volt_low_d = (volt_d != 16'd0) && (volt_d < volt_warn_q);
	assign brown_d    = (volt_d != 16'd0) && (volt_d < volt_min_q);

	// ------------------------------------------------------------------
	// State and pipeline registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			elapsed_q <= 16'd0;
			fired_q   <= 1'b0;
			det_q     <= 1'b0;
			tilt_q    <= 11'sd0;
			volt_q    <= VOLTAGE_RST;
		end else if (adv_s1) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
			fired_q   <= fired_d;
			det_q     <= det_d;
			tilt_q    <= tilt_d;
			volt_q    <= volt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata[IN_USED_W-1:0];
		end
		if (adv_s1) begin
			data_s2 <= {5'd0, det_d, brown_d, volt_low_d, release_d, kill_d,
				warn_ev_d, mode_d, left_d, failed_d, status_d};
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_kill_release_apart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[30] && m_tdata[31]))
		else $error("laser_kill and kill_release in the same result item");

	a_kill_means_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[30]) |-> (m_tdata[28:27] == MODE_SAFE))
		else $error("laser_kill without safe mode");

	a_safe_status_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] == ST_SAFE) |-> (m_tdata[10:4] == ALL_CHECKS))
		else $error("safe-mode status without a full failure mask");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(cmd_s1)))
		else $error("stalled input register lost its item");

	a_release_from_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && release_d) |-> (mode_q == MODE_SAFE))
		else $error("kill_release outside safe mode");

endmodule
